// ----- rtl/sprite_rle_row_decoder_top_macros.svh -----
// assertion macros for the sprite rle row decoder
// used by sprite_rle_row_decoder_top; no other dependencies
`ifndef SPRITE_RLE_ROW_DECODER_TOP_MACROS_SVH
`define SPRITE_RLE_ROW_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srle_pkg.sv -----
// shared types and constants for the sprite rle row decoder
// no dependencies
package srle_pkg;

    // result kinds
    localparam logic [1:0] KIND_RUN      = 2'd0;
    localparam logic [1:0] KIND_ROW_END  = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    // input op codes
    localparam logic OP_ROW_START = 1'b0;

    // command classes by low two bits of the command byte
    localparam logic [1:0] LOW2_LDRAW = 2'b00;
    localparam logic [1:0] LOW2_LSKIP = 2'b01;

    // command low nibbles
    localparam logic [3:0] NIB_GDRAW  = 4'h2;
    localparam logic [3:0] NIB_GSKIP  = 4'h3;
    localparam logic [3:0] NIB_PDRAW  = 4'h6;
    localparam logic [3:0] NIB_FILL   = 4'h7;
    localparam logic [3:0] NIB_PFILL  = 4'hA;
    localparam logic [3:0] NIB_SHADOW = 4'hB;
    localparam logic [3:0] NIB_EXT    = 4'hE;
    localparam logic [3:0] NIB_END    = 4'hF;
    localparam logic [3:0] NIB_LDRAW  = 4'h0;

    // full command bytes
    localparam logic [7:0] BYTE_ROW_END   = 8'h0F;
    localparam logic [7:0] BYTE_OUTL_PIX1 = 8'h4E;
    localparam logic [7:0] BYTE_OUTL_RUN1 = 8'h5E;
    localparam logic [7:0] BYTE_OUTL_PIX2 = 8'h6E;
    localparam logic [7:0] BYTE_OUTL_RUN2 = 8'h7E;
    localparam logic [3:0] HI_OUTL_RUN1   = 4'h5;

    // palette constants
    localparam logic [7:0] COLOR_OUTL1   = 8'd32;
    localparam logic [7:0] COLOR_OUTL2   = 8'd48;
    localparam logic [7:0] PLAYER_OFFSET = 8'd32;

    localparam logic [11:0] SAT12_MAX = 12'hFFF;

    typedef struct packed {
        logic        op;
        logic [7:0]  value;
        logic [11:0] row_index;
        logic [11:0] left_pad;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] row;
        logic [11:0] x_start;
        logic [11:0] run_length;
        logic [7:0]  color;
    } result_t;

endpackage

// ----- rtl/sprite_rle_row_decoder_top.sv -----
// sprite rle row decoder: one stream byte in per transaction, at most one pixel run out
// the decoder takes one transaction per clock when the output side keeps up; an
// item is held in the input register after its transaction and is decoded into the
// result register when that register is free or draining, from which the result is
// offered. the rate is set by the decode loop, which updates the row state (command
// phase, counts, x position) from each byte; the x position moves through one
// shared adder.
// a row-start transaction (op 0) loads the row and the left padding; command
// bytes then give runs (kind 0), overflowed runs (kind 2) or the row end (kind 1).
// a run that crosses MAX_WIDTH is clipped and x stays at MAX_WIDTH; rows at or
// past MAX_HEIGHT report every run as overflowed at full length.
// depends on srle_pkg, srle_in_stage, srle_decode, srle_out_stage and the macros header
`include "sprite_rle_row_decoder_top_macros.svh"

module sprite_rle_row_decoder_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,

    // command byte transactions
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  value,
    input  logic [11:0] row_index,
    input  logic [11:0] left_pad,

    // pixel run transactions
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [11:0] row_out,
    output logic [11:0] x_start,
    output logic [11:0] run_length,
    output logic [7:0]  color
);

    srle_pkg::in_item_t item_in;
    srle_pkg::in_item_t stage_item;
    srle_pkg::result_t  res;
    srle_pkg::result_t  res_q;
    logic               stage_valid;
    logic               advance;
    logic               res_valid;

    assign item_in.op        = op;
    assign item_in.value     = value;
    assign item_in.row_index = row_index;
    assign item_in.left_pad  = left_pad;

    // the held item is decoded when the result register is free or draining
    assign advance = stage_valid && (!out_valid || out_ready);

    srle_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    srle_decode #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (stage_item),
        .res_valid (res_valid),
        .res       (res)
    );

    srle_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_q     (res_q)
    );

    assign kind       = res_q.kind;
    assign row_out    = res_q.row;
    assign x_start    = res_q.x_start;
    assign run_length = res_q.run_length;
    assign color      = res_q.color;

    // row-end results carry no length or color
    `SRLE_ASSERT_NOW(a_row_end_empty, clk, rst_n, out_valid && kind == srle_pkg::KIND_ROW_END, run_length == 12'd0 && color == 8'd0, "row end with nonzero length or color")

    // plain runs are never empty
    `SRLE_ASSERT_NOW(a_run_nonempty, clk, rst_n, out_valid && kind == srle_pkg::KIND_RUN, run_length != 12'd0, "empty pixel run emitted")

    // an accepted transaction is held in the input register next cycle
    `SRLE_ASSERT_NEXT(a_in_captured, clk, rst_n, in_valid && in_ready, stage_valid, "accepted transaction lost")

    // decoding never overwrites a result still waiting at the output
    `SRLE_ASSERT_NOW(a_no_overwrite, clk, rst_n, advance, !out_valid || out_ready, "result overwritten while stalled")

endmodule

// ----- rtl/srle_in_stage.sv -----
// input register stage of the sprite rle row decoder
// depends on srle_pkg
module srle_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  srle_pkg::in_item_t  item_in,
    input  logic                advance,
    output logic                stage_valid,
    output srle_pkg::in_item_t  stage_item
);

    logic               valid_reg;
    srle_pkg::in_item_t item_reg;

    // a held item can be replaced in the cycle it moves on
    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// ----- rtl/srle_decode.sv -----
// command decoder and row state of the sprite rle row decoder
// depends on srle_pkg
module srle_decode #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  srle_pkg::in_item_t  item,
    output logic                res_valid,
    output srle_pkg::result_t   res
);

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int SW  = ((XW > 12) ? XW : 12) + 1;
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = (HCW > 12) ? HCW : 12;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_DONE,
        PH_LIT,
        PH_EXT,
        PH_COUNT,
        PH_COLOR
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [3:0]      cmd_kind_reg, cmd_kind_next;
    logic [3:0]      high_nibble_reg, high_nibble_next;
    logic [11:0]     remaining_reg, remaining_next;
    logic [XW-1:0]   x_pos_reg, x_pos_next;
    logic [11:0]     cur_row_reg, cur_row_next;

    logic [XW-1:0]   base;
    logic [11:0]     amt;
    logic            move;
    logic            emit_req;
    logic            row_end;
    logic [7:0]      emit_color;
    logic [SW-1:0]   sum;
    logic            over;
    logic [XW-1:0]   room;
    logic            row_beyond;
    logic            emit_ok;
    logic [11:0]     rem_dec;
    logic [11:0]     ext_count;
    logic [3:0]      nib;
    logic [3:0]      hi;

    function automatic logic [11:0] sat12(input logic [XW-1:0] v);
        return (SW'(v) > SW'(4095)) ? srle_pkg::SAT12_MAX : 12'(v);
    endfunction

    assign nib        = item.value[3:0];
    assign hi         = item.value[7:4];
    assign rem_dec    = remaining_reg - 12'd1;
    assign ext_count  = {high_nibble_reg, item.value};
    assign row_beyond = CW'(cur_row_reg) >= CW'(MAX_HEIGHT);

    // next state and the run request of this byte
    always_comb
    begin
        phase_next       = phase_reg;
        cmd_kind_next    = cmd_kind_reg;
        high_nibble_next = high_nibble_reg;
        remaining_next   = remaining_reg;
        cur_row_next     = cur_row_reg;
        base             = x_pos_reg;
        amt              = '0;
        move             = 1'b0;
        emit_req         = 1'b0;
        emit_color       = '0;
        row_end          = 1'b0;

        if (item.op == srle_pkg::OP_ROW_START)
        begin
            cur_row_next     = item.row_index;
            base             = '0;
            amt              = item.left_pad;
            move             = 1'b1;
            phase_next       = PH_CMD;
            cmd_kind_next    = '0;
            high_nibble_next = '0;
            remaining_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    priority if (nib[1:0] == srle_pkg::LOW2_LDRAW)
                    begin
                        cmd_kind_next  = srle_pkg::NIB_LDRAW;
                        remaining_next = 12'(item.value[7:2]);
                        phase_next     = (item.value[7:2] != '0) ? PH_LIT : PH_CMD;
                    end
                    else if (nib[1:0] == srle_pkg::LOW2_LSKIP)
                    begin
                        amt  = 12'(item.value[7:2]);
                        move = 1'b1;
                    end
                    else
                    begin
                        unique case (nib)
                            srle_pkg::NIB_GDRAW, srle_pkg::NIB_GSKIP:
                            begin
                                cmd_kind_next    = nib;
                                high_nibble_next = hi;
                                phase_next       = PH_EXT;
                            end
                            srle_pkg::NIB_PDRAW, srle_pkg::NIB_FILL,
                            srle_pkg::NIB_PFILL, srle_pkg::NIB_SHADOW:
                            begin
                                cmd_kind_next    = nib;
                                high_nibble_next = hi;
                                if (hi == '0)
                                begin
                                    phase_next = PH_COUNT;
                                end
                                else
                                begin
                                    remaining_next = 12'(hi);
                                    if (nib == srle_pkg::NIB_PDRAW)
                                    begin
                                        phase_next = PH_LIT;
                                    end
                                    else if (nib == srle_pkg::NIB_SHADOW)
                                    begin
                                        amt        = 12'(hi);
                                        move       = 1'b1;
                                        phase_next = PH_CMD;
                                    end
                                    else
                                    begin
                                        phase_next = PH_COLOR;
                                    end
                                end
                            end
                            srle_pkg::NIB_EXT:
                            begin
                                if (item.value == srle_pkg::BYTE_OUTL_PIX1 ||
                                    item.value == srle_pkg::BYTE_OUTL_PIX2)
                                begin
                                    amt        = 12'd1;
                                    move       = 1'b1;
                                    emit_req   = 1'b1;
                                    emit_color = (item.value == srle_pkg::BYTE_OUTL_PIX1) ?
                                                 srle_pkg::COLOR_OUTL1 :
                                                 srle_pkg::COLOR_OUTL2;
                                end
                                else if (item.value == srle_pkg::BYTE_OUTL_RUN1 ||
                                         item.value == srle_pkg::BYTE_OUTL_RUN2)
                                begin
                                    cmd_kind_next    = srle_pkg::NIB_EXT;
                                    high_nibble_next = hi;
                                    phase_next       = PH_COUNT;
                                end
                            end
                            srle_pkg::NIB_END:
                            begin
                                if (item.value == srle_pkg::BYTE_ROW_END)
                                begin
                                    phase_next = PH_DONE;
                                    row_end    = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                PH_LIT:
                begin
                    amt            = 12'd1;
                    move           = 1'b1;
                    emit_req       = 1'b1;
                    emit_color     = (cmd_kind_reg == srle_pkg::NIB_PDRAW) ?
                                     item.value + srle_pkg::PLAYER_OFFSET : item.value;
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_EXT:
                begin
                    phase_next = PH_CMD;
                    if (cmd_kind_reg == srle_pkg::NIB_GDRAW)
                    begin
                        remaining_next = ext_count;
                        cmd_kind_next  = srle_pkg::NIB_LDRAW;
                        if (ext_count != '0)
                        begin
                            phase_next = PH_LIT;
                        end
                    end
                    else
                    begin
                        amt            = ext_count;
                        move           = 1'b1;
                        remaining_next = '0;
                    end
                end
                PH_COUNT:
                begin
                    remaining_next = 12'(item.value);
                    if (cmd_kind_reg == srle_pkg::NIB_PDRAW)
                    begin
                        phase_next = (item.value != '0) ? PH_LIT : PH_CMD;
                    end
                    else if (cmd_kind_reg == srle_pkg::NIB_SHADOW)
                    begin
                        amt            = 12'(item.value);
                        move           = 1'b1;
                        remaining_next = '0;
                        phase_next     = PH_CMD;
                    end
                    else if (cmd_kind_reg == srle_pkg::NIB_EXT)
                    begin
                        amt            = 12'(item.value);
                        move           = 1'b1;
                        emit_req       = 1'b1;
                        emit_color     = (high_nibble_reg == srle_pkg::HI_OUTL_RUN1) ?
                                         srle_pkg::COLOR_OUTL1 : srle_pkg::COLOR_OUTL2;
                        remaining_next = '0;
                        phase_next     = PH_CMD;
                    end
                    else
                    begin
                        phase_next = PH_COLOR;
                    end
                end
                PH_COLOR:
                begin
                    amt            = remaining_reg;
                    move           = 1'b1;
                    emit_req       = 1'b1;
                    emit_color     = item.value;
                    remaining_next = '0;
                    phase_next     = PH_CMD;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // one shared adder for skips, runs and left padding
    assign sum        = SW'(base) + SW'(amt);
    assign over       = sum > SW'(MAX_WIDTH);
    assign room       = XW'(MAX_WIDTH) - x_pos_reg;
    assign emit_ok    = emit_req && (amt != '0);
    assign x_pos_next = move ? (over ? XW'(MAX_WIDTH) : XW'(sum)) : x_pos_reg;

    always_comb
    begin
        res.row     = cur_row_reg;
        res.x_start = sat12(x_pos_reg);
        if (row_end)
        begin
            res.kind       = srle_pkg::KIND_ROW_END;
            res.run_length = '0;
            res.color      = '0;
        end
        else
        begin
            res.kind       = (over || row_beyond) ? srle_pkg::KIND_OVERFLOW :
                             srle_pkg::KIND_RUN;
            res.run_length = (over && !row_beyond) ? sat12(room) : amt;
            res.color      = emit_color;
        end
    end

    assign res_valid = row_end || emit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CMD;
            cmd_kind_reg    <= '0;
            high_nibble_reg <= '0;
            remaining_reg   <= '0;
            x_pos_reg       <= '0;
            cur_row_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            cmd_kind_reg    <= cmd_kind_next;
            high_nibble_reg <= high_nibble_next;
            remaining_reg   <= remaining_next;
            x_pos_reg       <= x_pos_next;
            cur_row_reg     <= cur_row_next;
        end
    end

endmodule

// ----- rtl/srle_out_stage.sv -----
// result register of the sprite rle row decoder
// depends on srle_pkg
module srle_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               res_valid,
    input  srle_pkg::result_t  res,
    input  logic               out_ready,
    output logic               out_valid,
    output srle_pkg::result_t  res_q
);

    logic              valid_reg;
    srle_pkg::result_t res_reg;

    assign out_valid = valid_reg;
    assign res_q     = res_reg;

    // step only happens when the register is empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
